>>> sv/mexp_pkg.sv
// shared constants for the modular exponentiation chain
package mexp_pkg;

    localparam int DEFAULT_WORD_WIDTH = 32;
    localparam int KEY_WIDTH          = 32;
    localparam int PIXEL_WIDTH        = 16;

    localparam logic [63:0] KEY_PRIME_P = 64'd52223;
    localparam logic [63:0] KEY_PRIME_Q = 64'd50833;

    localparam logic [KEY_WIDTH-1:0] EXPONENT_RESET = 32'd758442487;
    localparam logic [KEY_WIDTH-1:0] MODULUS_RESET  = 32'(KEY_PRIME_P * KEY_PRIME_Q);

    typedef enum logic
    {
        CFG_EXPONENT = 1'b0,
        CFG_MODULUS  = 1'b1
    } cfg_index_t;

endpackage

>>> sv/mexp_red_cell.sv
// one restoring division step of the base reduction
module mexp_red_cell #(
    parameter int W = mexp_pkg::DEFAULT_WORD_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] modulus,
    input  logic         in_valid,
    input  logic [W-1:0] in_rem,
    input  logic [W-1:0] in_dvd,
    output logic         out_valid,
    output logic [W-1:0] out_rem,
    output logic [W-1:0] out_dvd
);

    logic         valid_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] dvd_reg;
    logic [W:0]   trial;
    logic [W-1:0] rem_next;

    always_comb
    begin
        trial = {in_rem, in_dvd[W-1]};
        if (trial >= {1'b0, modulus})
        begin
            trial = trial - {1'b0, modulus};
        end
        rem_next = trial[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= {in_dvd[W-2:0], 1'b0};
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dvd   = dvd_reg;

endmodule

>>> sv/mexp_mul_cell.sv
// one shift-and-add step of a modular multiplication
module mexp_mul_cell #(
    parameter int W    = mexp_pkg::DEFAULT_WORD_WIDTH,
    parameter int STEP = 0
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] modulus,
    input  logic         in_valid,
    input  logic [W-1:0] in_acc,
    input  logic [W-1:0] in_a,
    input  logic [W-1:0] in_b,
    input  logic [W-1:0] in_base,
    output logic         out_valid,
    output logic [W-1:0] out_acc,
    output logic [W-1:0] out_a,
    output logic [W-1:0] out_b,
    output logic [W-1:0] out_base
);

    localparam int BIT = W - 1 - STEP;

    logic         valid_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] base_reg;
    logic [W:0]   dbl;
    logic [W:0]   sum;
    logic [W-1:0] acc_next;

    always_comb
    begin
        dbl = {in_acc, 1'b0};
        if (dbl >= {1'b0, modulus})
        begin
            dbl = dbl - {1'b0, modulus};
        end
        sum = dbl;
        if (in_b[BIT])
        begin
            sum = dbl + {1'b0, in_a};
            if (sum >= {1'b0, modulus})
            begin
                sum = sum - {1'b0, modulus};
            end
        end
        acc_next = sum[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        a_reg    <= in_a;
        b_reg    <= in_b;
        base_reg <= in_base;
    end

    assign out_valid = valid_reg;
    assign out_acc   = acc_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_base  = base_reg;

endmodule

>>> sv/modular_exponentiation_32bit.sv
// top level: word ^ exponent mod modulus over a chain of bit-step cells
// One word is taken every cycle and busy is never raised. Each word runs through
// WORD_WIDTH reduction cells and then 2 * WORD_WIDTH * WORD_WIDTH multiply cells
// (a square and a multiply per exponent bit, one cell per multiplier bit), plus
// one output register. Its result appears for one cycle with done high; results
// must be taken then. The modulus is read live by every cell and the exponent by
// the multiply steps, so write them only while no word is in flight.
module modular_exponentiation_32bit #(
    parameter int WORD_WIDTH = mexp_pkg::DEFAULT_WORD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [mexp_pkg::KEY_WIDTH-1:0]       cipher_word,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [mexp_pkg::KEY_WIDTH-1:0]       cfg_data,
    output logic                                 done,
    output logic [mexp_pkg::KEY_WIDTH-1:0]       full_residue,
    output logic [mexp_pkg::PIXEL_WIDTH-1:0]     pixel_value
);

    localparam int W    = WORD_WIDTH;
    localparam int XW   = (W > mexp_pkg::KEY_WIDTH) ? W : mexp_pkg::KEY_WIDTH;
    localparam int NMUL = 2 * W * W;

    logic [W-1:0]  exp_reg;
    logic [W-1:0]  mod_reg;
    logic [XW-1:0] cfg_wide;
    logic [XW-1:0] word_wide;
    logic [XW-1:0] exp_rst_wide;
    logic [XW-1:0] mod_rst_wide;
    logic [XW-1:0] res_wide;
    logic [W-1:0]  init_acc;

    logic          r_v   [0:W];
    logic [W-1:0]  r_rem [0:W];
    logic [W-1:0]  r_dvd [0:W];

    logic          ci_v    [0:NMUL-1];
    logic [W-1:0]  ci_acc  [0:NMUL-1];
    logic [W-1:0]  ci_a    [0:NMUL-1];
    logic [W-1:0]  ci_b    [0:NMUL-1];
    logic [W-1:0]  ci_base [0:NMUL-1];
    logic          co_v    [0:NMUL-1];
    logic [W-1:0]  co_acc  [0:NMUL-1];
    logic [W-1:0]  co_a    [0:NMUL-1];
    logic [W-1:0]  co_b    [0:NMUL-1];
    logic [W-1:0]  co_base [0:NMUL-1];

    logic          done_reg;
    logic [W-1:0]  res_reg;
    logic [W-1:0]  res_next;

    assign cfg_wide     = XW'(cfg_data);
    assign word_wide    = XW'(cipher_word);
    assign exp_rst_wide = XW'(mexp_pkg::EXPONENT_RESET);
    assign mod_rst_wide = XW'(mexp_pkg::MODULUS_RESET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= exp_rst_wide[W-1:0];
            mod_reg <= mod_rst_wide[W-1:0];
        end
        else if (cfg_we)
        begin
            unique case (mexp_pkg::cfg_index_t'(cfg_index))
                mexp_pkg::CFG_EXPONENT: exp_reg <= cfg_wide[W-1:0];
                mexp_pkg::CFG_MODULUS:  mod_reg <= cfg_wide[W-1:0];
                default:                exp_reg <= exp_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // base reduction
    assign r_v[0]   = start;
    assign r_rem[0] = '0;
    assign r_dvd[0] = word_wide[W-1:0];

    genvar j;
    generate
        for (j = 0; j < W; j++)
        begin : g_red
            mexp_red_cell #(.W(W)) u_red (
                .clk       (clk),
                .rst_n     (rst_n),
                .modulus   (mod_reg),
                .in_valid  (r_v[j]),
                .in_rem    (r_rem[j]),
                .in_dvd    (r_dvd[j]),
                .out_valid (r_v[j+1]),
                .out_rem   (r_rem[j+1]),
                .out_dvd   (r_dvd[j+1])
            );
        end
    endgenerate

    assign init_acc = (mod_reg == W'(1)) ? '0 : W'(1);

    // square and multiply chain
    genvar c;
    generate
        for (c = 0; c < NMUL; c++)
        begin : g_mul
            localparam int OP = c / W;
            localparam int ST = c % W;
            if (ST != 0)
            begin : g_link
                assign ci_v[c]    = co_v[c-1];
                assign ci_acc[c]  = co_acc[c-1];
                assign ci_a[c]    = co_a[c-1];
                assign ci_b[c]    = co_b[c-1];
                assign ci_base[c] = co_base[c-1];
            end
            else if (OP == 0)
            begin : g_first
                assign ci_v[c]    = r_v[W];
                assign ci_acc[c]  = '0;
                assign ci_a[c]    = init_acc;
                assign ci_b[c]    = init_acc;
                assign ci_base[c] = r_rem[W];
            end
            else if ((OP % 2) == 0)
            begin : g_square
                assign ci_v[c]    = co_v[c-1];
                assign ci_acc[c]  = '0;
                assign ci_a[c]    = co_acc[c-1];
                assign ci_b[c]    = co_acc[c-1];
                assign ci_base[c] = co_base[c-1];
            end
            else
            begin : g_times
                localparam int EBIT = W - 1 - (OP / 2);
                assign ci_v[c]    = co_v[c-1];
                assign ci_acc[c]  = '0;
                assign ci_a[c]    = co_acc[c-1];
                assign ci_b[c]    = exp_reg[EBIT] ? co_base[c-1] : W'(1);
                assign ci_base[c] = co_base[c-1];
            end

            mexp_mul_cell #(.W(W), .STEP(ST)) u_mul (
                .clk       (clk),
                .rst_n     (rst_n),
                .modulus   (mod_reg),
                .in_valid  (ci_v[c]),
                .in_acc    (ci_acc[c]),
                .in_a      (ci_a[c]),
                .in_b      (ci_b[c]),
                .in_base   (ci_base[c]),
                .out_valid (co_v[c]),
                .out_acc   (co_acc[c]),
                .out_a     (co_a[c]),
                .out_b     (co_b[c]),
                .out_base  (co_base[c])
            );
        end
    endgenerate

    // result beat, zero modulus gives zero
    assign res_next = (mod_reg == '0) ? '0 : co_acc[NMUL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= co_v[NMUL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_wide     = XW'(res_reg);
    assign done         = done_reg;
    assign full_residue = res_wide[mexp_pkg::KEY_WIDTH-1:0];
    assign pixel_value  = res_wide[mexp_pkg::PIXEL_WIDTH-1:0];

endmodule
